>>> rtl/core/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg
// shared constants, types and helpers of the mask logit statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package mls_pkg;

    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int SWEEP_STEPS     = 10;

    // fixed field widths of the stream items
    localparam int SCORE_W = 16;
    localparam int SUM_W   = 36;
    localparam int HASH_W  = 32;
    localparam int FIELD_W = 21;
    localparam int SIDX_W  = 4;

    // internal counter width holds 2^MAX_PIXELS_LOG2 itself
    localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
    localparam int EIDX_W  = $clog2(SWEEP_STEPS + 1);

    localparam int OUT_DATA_W = 152;

    localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;

    localparam logic signed [SUM_W:0] SUM_MAX = 37'sd34359738367;
    localparam logic signed [SUM_W:0] SUM_MIN = -37'sd34359738368;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SWEEP   = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;

    // sweep levels in q8.8: 0, -2, -4, -5, -6, -7, -8, -10, -12, -14
    function automatic logic signed [SCORE_W-1:0] sweep_level(input int idx);
        logic signed [SCORE_W-1:0] lvl;
        begin
            unique case (idx)
                0:       lvl = 16'sd0;
                1:       lvl = -16'sd512;
                2:       lvl = -16'sd1024;
                3:       lvl = -16'sd1280;
                4:       lvl = -16'sd1536;
                5:       lvl = -16'sd1792;
                6:       lvl = -16'sd2048;
                7:       lvl = -16'sd2560;
                8:       lvl = -16'sd3072;
                default: lvl = -16'sd3584;
            endcase
            return lvl;
        end
    endfunction

    function automatic cnt_t sat_inc(input cnt_t c, input logic hit);
        begin
            if (hit && (c < CNT_LIMIT))
            begin
                return c + cnt_t'(1);
            end
            return c;
        end
    endfunction

    // low bits of a counter as an output field
    function automatic logic [FIELD_W-1:0] to_field(input cnt_t c);
        logic [63:0] wide;
        begin
            wide = 64'(c);
            return wide[FIELD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mask_logit_statistics.sv
// ----------------------------------------------------------------------------
// mask_logit_statistics
// per-frame min, max, sum, threshold counts and mask hash of a logit stream
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    tdata score, tlast last_pixel
// m_axis    out  m_tvalid/m_tready    tdata stats, tuser record_kind, tlast
// cfg       in   cfg_valid/cfg_ready  cfg_data mask_threshold
//
// one pixel item per cycle unless a last pixel is held: a pixel is held in the
// input register, the statistics update from it, the single hash multiply sets that path.
// a last pixel loads an output bank that sends 11 records, one per cycle
// while m_tready is high; ordinary pixels keep flowing meanwhile, a further
// last pixel waits in the input register until the bank has been emptied.
// rst_n clears all control state; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_logit_statistics
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mls_pkg::SCORE_W-1:0]   s_tdata,   // [15:0] score
    input  wire logic                          s_tlast,   // last_pixel

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] sweep_index, [24:4] count, [40:25] frame minimum,
    // [56:41] frame maximum, [92:57] frame sum, [124:93] mask fnv hash,
    // [145:125] pixel_count, rest zero
    output logic [mls_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser,   // [0] record_kind
    output logic                               m_tlast,   // last_result

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mls_pkg::SCORE_W-1:0]   cfg_data   // [15:0] mask_threshold
);

    import mls_pkg::*;

    logic signed [SCORE_W-1:0] threshold_reg;

    // input register
    logic                      in_valid_reg;
    logic signed [SCORE_W-1:0] in_score_reg;
    logic                      in_last_reg;

    // running frame state
    logic                      frame_open_reg;
    logic signed [SCORE_W-1:0] min_reg, min_next;
    logic signed [SCORE_W-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    cnt_t                      fg_reg, fg_next;
    cnt_t                      sweep_reg [SWEEP_STEPS];
    cnt_t                      sweep_next [SWEEP_STEPS];
    logic [HASH_W-1:0]         hash_reg, hash_next;
    cnt_t                      pix_reg, pix_next;

    // output bank
    logic                      bank_valid_reg;
    logic [EIDX_W-1:0]         emit_idx_reg;
    logic signed [SCORE_W-1:0] bank_min_reg;
    logic signed [SCORE_W-1:0] bank_max_reg;
    logic signed [SUM_W-1:0]   bank_sum_reg;
    cnt_t                      bank_fg_reg;
    cnt_t                      bank_sweep_reg [SWEEP_STEPS];
    logic [HASH_W-1:0]         bank_hash_reg;
    cnt_t                      bank_pix_reg;

    logic advance;
    logic out_take;
    logic emit_done;
    logic bank_busy;
    logic bank_load;

    assign cfg_ready = 1'b1;

    assign out_take  = m_tvalid && m_tready;
    assign emit_done = out_take && (emit_idx_reg == EIDX_W'(SWEEP_STEPS));
    assign bank_busy = bank_valid_reg && !emit_done;
    assign advance   = in_valid_reg && !(in_last_reg && bank_busy);
    assign bank_load = advance && in_last_reg;
    assign s_tready  = !in_valid_reg || advance;

    // statistics update for the pixel in the input register
    always_comb
    begin
        logic signed [SCORE_W-1:0] base_min;
        logic signed [SCORE_W-1:0] base_max;
        logic signed [SUM_W-1:0]   base_sum;
        cnt_t                      base_fg;
        logic [HASH_W-1:0]         base_hash;
        cnt_t                      base_pix;
        logic signed [SUM_W:0]     sum_wide;
        logic                      fg_bit;

        if (frame_open_reg)
        begin
            base_min  = min_reg;
            base_max  = max_reg;
            base_sum  = sum_reg;
            base_fg   = fg_reg;
            base_hash = hash_reg;
            base_pix  = pix_reg;
        end
        else
        begin
            base_min  = in_score_reg;
            base_max  = in_score_reg;
            base_sum  = '0;
            base_fg   = '0;
            base_hash = HASH_BASIS;
            base_pix  = '0;
        end

        min_next = (in_score_reg < base_min) ? in_score_reg : base_min;
        max_next = (in_score_reg > base_max) ? in_score_reg : base_max;

        sum_wide = (SUM_W+1)'(base_sum) + (SUM_W+1)'(in_score_reg);
        if (sum_wide > SUM_MAX)
        begin
            sum_next = SUM_W'(SUM_MAX);
        end
        else if (sum_wide < SUM_MIN)
        begin
            sum_next = SUM_W'(SUM_MIN);
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end

        for (int i = 0; i < SWEEP_STEPS; i++)
        begin
            sweep_next[i] = sat_inc(frame_open_reg ? sweep_reg[i] : '0,
                                    in_score_reg > sweep_level(i));
        end

        fg_bit    = in_score_reg > threshold_reg;
        fg_next   = sat_inc(base_fg, fg_bit);
        hash_next = (base_hash ^ HASH_W'(fg_bit)) * HASH_PRIME;
        pix_next  = sat_inc(base_pix, 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            in_valid_reg   <= 1'b0;
            frame_open_reg <= 1'b0;
            bank_valid_reg <= 1'b0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end

            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (advance)
            begin
                frame_open_reg <= !in_last_reg;
            end

            if (bank_load)
            begin
                bank_valid_reg <= 1'b1;
                emit_idx_reg   <= '0;
            end
            else if (emit_done)
            begin
                bank_valid_reg <= 1'b0;
                emit_idx_reg   <= '0;
            end
            else if (out_take)
            begin
                emit_idx_reg <= emit_idx_reg + EIDX_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_score_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end

        if (advance)
        begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            sum_reg  <= sum_next;
            fg_reg   <= fg_next;
            hash_reg <= hash_next;
            pix_reg  <= pix_next;
            for (int i = 0; i < SWEEP_STEPS; i++)
            begin
                sweep_reg[i] <= sweep_next[i];
            end
        end

        if (bank_load)
        begin
            bank_min_reg  <= min_next;
            bank_max_reg  <= max_next;
            bank_sum_reg  <= sum_next;
            bank_fg_reg   <= fg_next;
            bank_hash_reg <= hash_next;
            bank_pix_reg  <= pix_next;
            for (int i = 0; i < SWEEP_STEPS; i++)
            begin
                bank_sweep_reg[i] <= sweep_next[i];
            end
        end
    end

    // record select: index 0 is the summary, then one record per sweep level
    always_comb
    begin
        logic [FIELD_W-1:0] sweep_cnt;
        logic [SIDX_W-1:0]  sweep_idx;

        sweep_cnt = '0;
        sweep_idx = '0;
        for (int i = 0; i < SWEEP_STEPS; i++)
        begin
            if (emit_idx_reg == EIDX_W'(i + 1))
            begin
                sweep_cnt = to_field(bank_sweep_reg[i]);
                sweep_idx = SIDX_W'(i);
            end
        end

        m_tvalid = bank_valid_reg;
        m_tdata  = '0;
        if (emit_idx_reg == '0)
        begin
            m_tuser[0]       = KIND_SUMMARY;
            m_tlast          = 1'b0;
            m_tdata[24:4]    = to_field(bank_fg_reg);
            m_tdata[40:25]   = bank_min_reg;
            m_tdata[56:41]   = bank_max_reg;
            m_tdata[92:57]   = bank_sum_reg;
            m_tdata[124:93]  = bank_hash_reg;
            m_tdata[145:125] = to_field(bank_pix_reg);
        end
        else
        begin
            m_tuser[0]    = KIND_SWEEP;
            m_tlast       = emit_idx_reg == EIDX_W'(SWEEP_STEPS);
            m_tdata[3:0]  = sweep_idx;
            m_tdata[24:4] = sweep_cnt;
        end
    end

    // checks

    a_emit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_idx_reg <= EIDX_W'(SWEEP_STEPS))
        else $error("record index beyond the last sweep record");

    a_load_starts_summary: assert property (@(posedge clk) disable iff (!rst_n)
        bank_load |=> (m_tvalid && (emit_idx_reg == '0) && !frame_open_reg))
        else $error("frame end did not start a summary record");

    a_drain_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_done && !bank_load) |=> (!m_tvalid && (emit_idx_reg == '0)))
        else $error("bank not released after the final record");

    a_pix_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_open_reg |-> (pix_reg <= CNT_LIMIT)))
        else $error("pixel counter past its limit");

endmodule

`default_nettype wire

>>> dv/tb_mask_logit_statistics.sv
// ----------------------------------------------------------------------------
// tb_mask_logit_statistics
// self-checking bench for the mask logit statistics block
// ----------------------------------------------------------------------------
// pixels go in on the s_axis stream in bursts with random gaps, and records
// come out on m_axis under a changing stall pattern. A predictor in the bench
// tracks min, max, saturating sum and counts and the FNV-1a mask hash per
// frame, and queues the eleven records of each closed frame. Every record
// that comes out is compared field by field with the oldest queued record.
// The directed table has single pixel frames with hand-computed summaries and
// one frame that walks the sweep thresholds. Random frames run under
// several mask thresholds, the extremes among them. A short frame at full
// rate with extreme logits closes the run.
// ----------------------------------------------------------------------------

module tb_mask_logit_statistics;

    localparam int SWEEPS        = mls_pkg::SWEEP_STEPS;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_GOAL   = 18;   // minimum pixels per threshold setting

    localparam int unsigned PIXEL_CAP = 1 << mls_pkg::MAX_PIXELS_LOG2;
    localparam longint SUM_HI = 64'sd34359738367;
    localparam longint SUM_LO = -64'sd34359738368;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;

    typedef struct packed {
        logic        kind;
        logic [3:0]  sweep_index;
        logic [20:0] count;
        logic [15:0] low_score;
        logic [15:0] high_score;
        logic [35:0] logit_total;
        logic [31:0] mask_fnv;
        logic [20:0] pixel_count;
        logic [5:0]  pad;
        logic        last;
    } stat_rec_t;

    typedef struct packed {
        logic [15:0] score;
        logic        last;
        logic        typed;
        logic [20:0] count;
        logic [15:0] low_score;
        logic [15:0] high_score;
        logic [35:0] logit_total;
        logic [31:0] mask_fnv;
    } pix_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [mls_pkg::SCORE_W-1:0]         s_tdata   = '0;   // [15:0] score
    logic                                s_tlast   = 1'b0; // last_pixel

    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    // [3:0] sweep_index, [24:4] count, [40:25] frame minimum,
    // [56:41] frame maximum, [92:57] frame sum, [124:93] mask fnv hash,
    // [145:125] pixel_count
    logic [mls_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [0:0]                          m_tuser;          // [0] record_kind
    logic                                m_tlast;          // last_result

    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [mls_pkg::SCORE_W-1:0]         cfg_data  = '0;   // [15:0] mask_threshold

    // predictor state
    logic signed [15:0] mask_thr     = '0;
    logic signed [15:0] frame_min    = '0;
    logic signed [15:0] frame_max    = '0;
    longint             frame_sum    = 0;
    int unsigned        fg_pixels    = 0;
    int unsigned        sweep_pixels [SWEEPS];
    logic [31:0]        frame_hash   = FNV_BASIS;
    int unsigned        frame_pixels = 0;
    logic               in_frame     = 1'b0;

    stat_rec_t expected_records [$];

    int mismatches      = 0;
    int records_checked = 0;
    int pixels_sent     = 0;
    int frames_closed   = 0;
    int thresholds_used = 0;

    logic     gaps_on    = 1'b1;
    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_tick    = 0;

    mask_logit_statistics u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [15:0] sweep_q88(input int k);
        case (k)
            0:       return 16'sd0;
            1:       return -16'sd512;
            2:       return -16'sd1024;
            3:       return -16'sd1280;
            4:       return -16'sd1536;
            5:       return -16'sd1792;
            6:       return -16'sd2048;
            7:       return -16'sd2560;
            8:       return -16'sd3072;
            default: return -16'sd3584;
        endcase
    endfunction

    function automatic int unsigned capped_inc(input int unsigned c, input logic hit);
        return (hit && c < PIXEL_CAP) ? c + 1 : c;
    endfunction

    // fold one pixel into the frame statistics, queue records on a last pixel
    function automatic void absorb_pixel(input logic signed [15:0] sc, input logic lst);
        stat_rec_t rec;
        logic      hit;
        int        k;
        if (!in_frame)
        begin
            frame_min    = sc;
            frame_max    = sc;
            frame_sum    = 0;
            fg_pixels    = 0;
            frame_hash   = FNV_BASIS;
            frame_pixels = 0;
            for (k = 0; k < SWEEPS; k++)
                sweep_pixels[k] = 0;
            in_frame = 1'b1;
        end
        if (sc < frame_min)
            frame_min = sc;
        if (sc > frame_max)
            frame_max = sc;
        frame_sum = frame_sum + longint'(sc);
        if (frame_sum > SUM_HI)
            frame_sum = SUM_HI;
        if (frame_sum < SUM_LO)
            frame_sum = SUM_LO;
        for (k = 0; k < SWEEPS; k++)
            sweep_pixels[k] = capped_inc(sweep_pixels[k], sc > sweep_q88(k));
        hit          = (sc > mask_thr);
        fg_pixels    = capped_inc(fg_pixels, hit);
        frame_hash   = (frame_hash ^ {31'b0, hit}) * FNV_PRIME;
        frame_pixels = capped_inc(frame_pixels, 1'b1);

        if (lst)
        begin
            rec             = '0;
            rec.kind        = mls_pkg::KIND_SUMMARY;
            rec.count       = fg_pixels[20:0];
            rec.low_score   = frame_min;
            rec.high_score  = frame_max;
            rec.logit_total = frame_sum[35:0];
            rec.mask_fnv    = frame_hash;
            rec.pixel_count = frame_pixels[20:0];
            expected_records = {expected_records, rec};
            for (k = 0; k < SWEEPS; k++)
            begin
                rec             = '0;
                rec.kind        = mls_pkg::KIND_SWEEP;
                rec.sweep_index = 4'(k);
                rec.count       = sweep_pixels[k][20:0];
                rec.last        = (k == SWEEPS - 1);
                expected_records = {expected_records, rec};
            end
            in_frame = 1'b0;
            frames_closed++;
        end
    endfunction

    function automatic pix_row_t plain_row(input logic [15:0] sc, input logic lst);
        pix_row_t r;
        r       = '0;
        r.score = sc;
        r.last  = lst;
        return r;
    endfunction

    // single pixel frame with the summary worked out by hand
    function automatic pix_row_t typed_row(input logic [15:0] sc, input logic [20:0] cnt,
                                           input logic [15:0] mn, input logic [15:0] mx,
                                           input logic [35:0] sum, input logic [31:0] hash);
        pix_row_t r;
        r             = '0;
        r.score       = sc;
        r.last        = 1'b1;
        r.typed       = 1'b1;
        r.count       = cnt;
        r.low_score   = mn;
        r.high_score  = mx;
        r.logit_total = sum;
        r.mask_fnv    = hash;
        return r;
    endfunction

    // rows 0..2 assume the reset threshold of zero
    function automatic pix_row_t directed_row(input int idx);
        case (idx)
            0:  return typed_row(16'sh0000, 21'd0, 16'sh0000, 16'sh0000, 36'sd0,
                                 32'h050c5d1f);
            1:  return typed_row(16'sh7fff, 21'd1, 16'sh7fff, 16'sh7fff, 36'sd32767,
                                 32'h040c5b8c);
            2:  return typed_row(16'sh8000, 21'd0, 16'sh8000, 16'sh8000, -36'sd32768,
                                 32'h050c5d1f);
            // one frame across the sweep thresholds and their neighbors
            3:  return plain_row(16'h5555, 1'b0);
            4:  return plain_row(16'haaaa, 1'b0);
            5:  return plain_row(-16'sd512, 1'b0);
            6:  return plain_row(-16'sd511, 1'b0);
            7:  return plain_row(-16'sd513, 1'b0);
            8:  return plain_row(-16'sd1024, 1'b0);
            9:  return plain_row(-16'sd1280, 1'b0);
            10: return plain_row(-16'sd1279, 1'b0);
            11: return plain_row(-16'sd1536, 1'b0);
            12: return plain_row(-16'sd1792, 1'b0);
            13: return plain_row(-16'sd2048, 1'b0);
            14: return plain_row(-16'sd2560, 1'b0);
            15: return plain_row(-16'sd3072, 1'b0);
            16: return plain_row(-16'sd3584, 1'b0);
            17: return plain_row(-16'sd3583, 1'b0);
            18: return plain_row(-16'sd3585, 1'b0);
            19: return plain_row(16'sd1, 1'b0);
            20: return plain_row(-16'sd1, 1'b0);
            21: return plain_row(16'sh7fff, 1'b0);
            default: return plain_row(16'sh8000, 1'b1);
        endcase
    endfunction

    function automatic logic [15:0] pick_score();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535));
            4, 5:       v = int'(sweep_q88(int'($urandom_range(0, SWEEPS - 1))))
                            + int'($urandom_range(0, 2)) - 1;
            6:          v = int'(mask_thr) + int'($urandom_range(0, 2)) - 1;
            7:          v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default:    v = int'($urandom_range(0, 5120)) - 4096;
        endcase
        return v[15:0];
    endfunction

    task automatic feed_pixel(input logic [15:0] sc, input logic lst);
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_pixel(sc, lst);
        pixels_sent++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // lower valid right after the last accepted item of a phase
    task automatic end_stream();
        s_tvalid <= 1'b0;
    endtask

    // wait out queued records and any pixels still in the pipeline
    task automatic drain_records();
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mask_thr = v;
        thresholds_used++;
    endtask

    task automatic run_random_frames(input int pixel_goal);
        int sent;
        int flen;
        int k;
        sent = 0;
        while (sent < pixel_goal)
        begin
            flen    = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(1, 6);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (k = 0; k < flen; k++)
                feed_pixel(pick_score(), k == flen - 1);
            sent += flen;
        end
    endtask

    // receiver stall pattern, switching to a random mode when its tick counter runs out
    always @(posedge clk)
    begin
        if (rx_tick == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_tick <= $urandom_range(20, 80);
        end
        else
        begin
            rx_tick <= rx_tick - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
            RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
            default:   m_tready <= (rx_tick % 12 >= 9);
        endcase
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("record %0d: %s expected %0h, got %0h",
                         records_checked, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : record_check
        stat_rec_t want;
        stat_rec_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind        = m_tuser[0];
            got.sweep_index = m_tdata[3:0];
            got.count       = m_tdata[24:4];
            got.low_score   = m_tdata[40:25];
            got.high_score  = m_tdata[56:41];
            got.logit_total = m_tdata[92:57];
            got.mask_fnv    = m_tdata[124:93];
            got.pixel_count = m_tdata[145:125];
            got.pad         = m_tdata[151:146];
            got.last        = m_tlast;
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record %0d arrived with none expected, tdata %0h",
                             records_checked, m_tdata);
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("record_kind", want.kind, got.kind);
                check_field("sweep_index", want.sweep_index, got.sweep_index);
                check_field("count", want.count, got.count);
                check_field("frame minimum", want.low_score, got.low_score);
                check_field("frame maximum", want.high_score, got.high_score);
                check_field("frame sum", want.logit_total, got.logit_total);
                check_field("mask fnv hash", want.mask_fnv, got.mask_fnv);
                check_field("pixel_count", want.pixel_count, got.pixel_count);
                check_field("tdata padding", want.pad, got.pad);
                check_field("last_result", want.last, got.last);
            end
            records_checked++;
        end
    end

    initial
    begin : stimulus
        pix_row_t  row;
        stat_rec_t pinned;
        int        row_idx;
        int        pin_at;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table under the reset threshold
        gaps_on = 1'b1;
        for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++)
        begin
            row = directed_row(row_idx);
            feed_pixel(row.score, row.last);
            if (row.typed)
            begin
                // summary sits just ahead of the sweep records of this frame
                pin_at             = expected_records.size() - 1 - SWEEPS;
                pinned             = expected_records[pin_at];
                pinned.count       = row.count;
                pinned.low_score   = row.low_score;
                pinned.high_score  = row.high_score;
                pinned.logit_total = row.logit_total;
                pinned.mask_fnv    = row.mask_fnv;
                pinned.pixel_count = 21'd1;
                expected_records[pin_at] = pinned;
            end
        end
        end_stream();
        drain_records();

        // random frames under several thresholds, extremes first
        set_threshold(16'sh8000);
        run_random_frames(RANDOM_GOAL);
        end_stream();
        drain_records();

        set_threshold(16'sh7fff);
        run_random_frames(RANDOM_GOAL);
        end_stream();
        drain_records();

        set_threshold(16'($urandom));
        run_random_frames(RANDOM_GOAL);
        end_stream();
        drain_records();

        // threshold equal to a sweep level
        set_threshold(-16'sd512);
        run_random_frames(RANDOM_GOAL);
        end_stream();
        drain_records();

        set_threshold(16'($urandom_range(0, 4095)) - 16'sd2048);
        run_random_frames(RANDOM_GOAL);
        end_stream();
        drain_records();

        // one frame at full rate with extremes and values around the threshold
        set_threshold(16'sh0100);
        gaps_on = 1'b0;
        feed_pixel(16'sh7fff, 1'b0);
        feed_pixel(16'sh7fff, 1'b0);
        feed_pixel(16'sh8000, 1'b0);
        feed_pixel(16'sd100, 1'b0);
        feed_pixel(16'sh0101, 1'b0);
        feed_pixel(16'sh0100, 1'b0);
        feed_pixel(-16'sd3584, 1'b0);
        feed_pixel(16'sh7fff, 1'b1);
        end_stream();
        drain_records();

        $display("covered %0d pixels in %0d frames, directed, random and full rate",
                 pixels_sent, frames_closed);
        $display("%0d records checked under %0d mask thresholds, %0d mismatches",
                 records_checked, thresholds_used, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(400_000);
        $display("run stopped by timeout, %0d records still expected",
                 expected_records.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mls_pkg.sv
rtl/core/mask_logit_statistics.sv
dv/tb_mask_logit_statistics.sv
